>>> rtl/core/emab_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emab_pkg
// Shared widths, types and constants for the baseline motion detector.
// ----------------------------------------------------------------------------
package emab_pkg;

	localparam int SAMPLE_W = 10;
	localparam int FRAC_W   = 16;
	localparam int BASE_W   = SAMPLE_W + FRAC_W;
	localparam int DEV_W    = 16;
	localparam int THR_W    = 8;
	localparam int STEP_SH  = 10;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [BASE_W-1:0]   baseline_t;
	typedef logic [DEV_W-1:0]    dev_t;
	typedef logic [THR_W-1:0]    thr_t;

	localparam dev_t PRIME_DEV = '1;

endpackage : emab_pkg
`default_nettype wire

>>> rtl/core/emab_update.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emab_update
// Baseline step, deviation and threshold compare for one sample.
// ----------------------------------------------------------------------------
module emab_update (
	input  wire emab_pkg::sample_t   sample,
	input  wire emab_pkg::baseline_t baseline,
	input  wire logic                all_primed,
	input  wire emab_pkg::thr_t      threshold,
	output emab_pkg::baseline_t      new_baseline,
	output emab_pkg::dev_t           deviation,
	output emab_pkg::dev_t           motion_level
);
	import emab_pkg::*;

	logic signed [BASE_W:0]   target;
	logic signed [BASE_W:0]   delta;
	logic signed [BASE_W:0]   step;
	logic signed [BASE_W+1:0] nb;
	logic        [BASE_W:0]   mag;

	assign target = $signed({1'b0, sample, {FRAC_W{1'b0}}});
	assign delta  = target - $signed({1'b0, baseline});

	// divide by 1024, truncating toward zero
	assign step = delta[BASE_W] ? ((delta + (BASE_W+1)'(1023)) >>> STEP_SH)
	                            : (delta >>> STEP_SH);
	assign nb   = $signed({2'b00, baseline}) + (BASE_W+2)'(step);
	assign mag  = delta[BASE_W] ? (BASE_W+1)'(-delta) : (BASE_W+1)'(delta);

	always_comb begin
		if (!all_primed) begin
			new_baseline = {sample, {FRAC_W{1'b0}}};
			deviation    = PRIME_DEV;
		end else begin
			new_baseline = nb[BASE_W+1] ? '0 : nb[BASE_W-1:0];
			deviation    = DEV_W'(mag[BASE_W:FRAC_W]);
		end
		motion_level = (deviation > DEV_W'(threshold)) ? deviation : '0;
	end

endmodule : emab_update
`default_nettype wire

>>> rtl/core/emab_chan_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emab_chan_regs
// Per-channel baseline and primed flags, one read-modify-write per cycle.
// ----------------------------------------------------------------------------
module emab_chan_regs #(
	parameter int CHANNELS = 2,
	parameter int IDX_W    = 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                we,
	input  wire logic [IDX_W-1:0]    idx,
	input  wire emab_pkg::baseline_t wr_baseline,
	output emab_pkg::baseline_t      rd_baseline,
	output logic                     all_primed
);
	import emab_pkg::*;

	baseline_t            baseline_q [CHANNELS];
	logic [CHANNELS-1:0]  primed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				baseline_q[i] <= '0;
			end
			primed_q <= '0;
		end else if (we) begin
			baseline_q[idx] <= wr_baseline;
			primed_q[idx]   <= 1'b1;
		end
	end

	assign rd_baseline = baseline_q[idx];
	assign all_primed  = &primed_q;

endmodule : emab_chan_regs
`default_nettype wire

>>> rtl/core/ema_baseline_motion_detector_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ema_baseline_motion_detector_top
// Per-channel EMA baseline tracker with deviation threshold.
// Stages: input reg, then result reg, which drives result valid.
// Throughput: one item per cycle unless the result side stalls; per-channel
// state is read and written in the same cycle, so back-to-back samples on one
// channel see the update.
// Reset: baselines, primed flags and threshold clear; pipeline empties.
// ----------------------------------------------------------------------------
module ema_baseline_motion_detector_top #(
	parameter int CHANNELS = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              channel,
	input  wire emab_pkg::sample_t sample,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output emab_pkg::dev_t         deviation,
	output emab_pkg::dev_t         motion_level,
	input  wire logic              cfg_we,
	input  wire emab_pkg::thr_t    cfg_wdata
);
	import emab_pkg::*;

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	thr_t      threshold_q;
	logic      valid_s1;
	logic      channel_s1;
	sample_t   sample_s1;
	logic      out_valid_q;
	dev_t      deviation_q;
	dev_t      motion_q;

	logic      advance;
	logic      in_range;
	logic      all_primed;
	baseline_t rd_baseline;
	baseline_t new_baseline;
	dev_t      dev_c;
	dev_t      motion_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
		end else if (cfg_we) begin
			threshold_q <= cfg_wdata;
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_range = 32'(channel_s1) < CHANNELS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			channel_s1 <= channel;
			sample_s1  <= sample;
		end
	end

	emab_chan_regs #(
		.CHANNELS (CHANNELS),
		.IDX_W    (IDX_W)
	) u_chan_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.we          (advance && in_range),
		.idx         (IDX_W'(channel_s1)),
		.wr_baseline (new_baseline),
		.rd_baseline (rd_baseline),
		.all_primed  (all_primed)
	);

	emab_update u_update (
		.sample       (sample_s1),
		.baseline     (rd_baseline),
		.all_primed   (all_primed),
		.threshold    (threshold_q),
		.new_baseline (new_baseline),
		.deviation    (dev_c),
		.motion_level (motion_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			deviation_q <= in_range ? dev_c : '0;
			motion_q    <= in_range ? motion_c : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign deviation    = deviation_q;
	assign motion_level = motion_q;

endmodule : ema_baseline_motion_detector_top
`default_nettype wire

>>> tb/ema_baseline_motion_detector_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ema_baseline_motion_detector_top_test
// Self-checking bench for the baseline motion detector. Samples are sent with
// random gaps while the result side stalls at random. The bench tracks each
// channel's baseline, the primed flags and the threshold. It predicts the
// deviation and the motion level of every input transfer and checks the
// result transfers in order.
// ----------------------------------------------------------------------------
module ema_baseline_motion_detector_top_test;
	import emab_pkg::*;

	localparam int NUM_CH        = 2;
	localparam int STEP_DIV      = 1024;
	localparam int UNIT_DIV      = 65536;
	localparam int SAMPLE_MAX    = 1023;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_PHASES = 11;
	localparam int PHASE_ITEMS   = 100;

	typedef struct packed {
		dev_t deviation;
		dev_t motion_level;
	} motion_result_t;

	logic    clk;
	logic    arst_n;
	logic    in_valid;
	logic    in_ready;
	logic    channel;
	sample_t sample;
	logic    out_valid;
	logic    out_ready;
	dev_t    deviation;
	dev_t    motion_level;
	logic    cfg_we;
	thr_t    cfg_wdata;

	baseline_t      baseline_q [NUM_CH];
	bit             primed_q [NUM_CH];
	thr_t           threshold_q;
	motion_result_t pending_results [$];
	motion_result_t expected_now;
	int             errors = 0;
	int             cycles = 0;
	bit             quiet = 1'b0;

	ema_baseline_motion_detector_top #(
		.CHANNELS(NUM_CH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.channel(channel),
		.sample(sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.deviation(deviation),
		.motion_level(motion_level),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic motion_result_t predict_motion(input logic ch, input sample_t smp);
		motion_result_t r;
		longint         delta;
		longint         nb;
		longint         q;
		bit             all_primed;
		int             k;
		all_primed = 1'b1;
		for (k = 0; k < NUM_CH; k++)
			if (!primed_q[k])
				all_primed = 1'b0;
		if (!all_primed) begin
			baseline_q[ch] = baseline_t'({smp, 16'h0000});
			primed_q[ch]   = 1'b1;
			r.deviation    = PRIME_DEV;
		end else begin
			delta = (longint'(smp) <<< FRAC_W) - longint'(baseline_q[ch]);
			nb    = longint'(baseline_q[ch]) + delta / STEP_DIV;
			q     = delta / UNIT_DIV;
			if (nb < 0)
				nb = 0;
			if (q < 0)
				q = -q;
			baseline_q[ch] = nb[BASE_W-1:0];
			r.deviation    = q[DEV_W-1:0];
		end
		r.motion_level = (r.deviation > dev_t'(threshold_q)) ? r.deviation : '0;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_stall();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		if (r < 99)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	function automatic sample_t offset_sample(input int cur, input int off);
		if (cur + off <= SAMPLE_MAX)
			return sample_t'(cur + off);
		if (cur - off >= 0)
			return sample_t'(cur - off);
		return sample_t'(SAMPLE_MAX);
	endfunction

	function automatic sample_t random_sample(input logic ch);
		int r;
		int cur;
		r   = $urandom_range(0, 99);
		cur = int'(baseline_q[ch] >> FRAC_W);
		if (r < 50)
			return offset_sample(cur, $urandom_range(0, 400));
		if (r < 72)
			return offset_sample(cur, int'(threshold_q) + $urandom_range(0, 2));
		if (r < 90)
			return sample_t'($urandom_range(0, SAMPLE_MAX));
		return ($urandom_range(0, 1) != 0) ? sample_t'(SAMPLE_MAX) : '0;
	endfunction

	task automatic send_sample(input logic ch, input sample_t smp);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		channel  <= ch;
		sample   <= smp;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(predict_motion(ch, smp));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_threshold(input thr_t thr);
		wait_idle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= thr;
		@(negedge clk);
		cfg_we    <= 1'b0;
		threshold_q = thr;
	endtask

	// reload of a primed channel while the other is still unprimed, then updates
	task automatic test_priming();
		send_sample(1'b0, sample_t'(SAMPLE_MAX));
		send_sample(1'b0, '0);
		send_sample(1'b0, sample_t'(17));
		send_sample(1'b1, sample_t'(512));
		send_sample(1'b1, sample_t'(512));
		send_sample(1'b0, sample_t'(SAMPLE_MAX));
	endtask

	task automatic test_sample_extremes();
		write_threshold('0);
		send_sample(1'b0, '0);
		send_sample(1'b0, sample_t'(SAMPLE_MAX));
		send_sample(1'b1, '0);
		send_sample(1'b1, sample_t'(SAMPLE_MAX));
		send_sample(1'b0, 10'h155);
		send_sample(1'b1, 10'h2aa);
		send_sample(1'b0, 10'h2aa);
	endtask

	task automatic test_threshold_edges();
		int ch;
		int off;
		write_threshold(8'hff);
		for (ch = 0; ch < NUM_CH; ch++)
			for (off = 255; off <= 257; off++)
				send_sample(ch[0], offset_sample(int'(baseline_q[ch] >> FRAC_W), off));
	endtask

	task automatic test_random();
		int   phase;
		int   i;
		logic ch;
		thr_t thr;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: thr = '0;
				1: thr = 8'hff;
				2: thr = 8'h01;
				3: thr = 8'hfe;
				default: thr = thr_t'($urandom_range(0, 255));
			endcase
			write_threshold(thr);
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if (i % 25 == 0)
					quiet = ($urandom_range(0, 3) == 0);
				ch = logic'($urandom_range(0, 1));
				send_sample(ch, random_sample(ch));
			end
			quiet = 1'b0;
		end
	endtask

	initial begin : result_ready_drive
		int stall;
		stall     = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				if (!quiet)
					stall = pick_stall();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result transfer: deviation %0d motion_level %0d",
					$time, deviation, motion_level);
			end else begin
				expected_now = pending_results.pop_front();
				if (deviation !== expected_now.deviation) begin
					errors++;
					$display("%0t: deviation mismatch: expected %0d, actual %0d",
						$time, expected_now.deviation, deviation);
				end
				if (motion_level !== expected_now.motion_level) begin
					errors++;
					$display("%0t: motion_level mismatch: expected %0d, actual %0d",
						$time, expected_now.motion_level, motion_level);
				end
			end
		end
	end

	initial begin
		for (int k = 0; k < NUM_CH; k++) begin
			baseline_q[k] = '0;
			primed_q[k]   = 1'b0;
		end
		threshold_q = '0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		channel     = 1'b0;
		sample      = '0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_priming();
		test_sample_extremes();
		test_threshold_edges();
		test_random();

		wait_idle();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
